>>> src/dqg_pkg.sv
// shared types, constants and helper functions for the uint8 dequantizing gemv core
package dqg_pkg;

  localparam int LANES     = 4;
  localparam int LANE_W    = $clog2(LANES);
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);
  localparam int EXP_W     = 13;

  localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
  localparam logic [31:0] ONE_BITS  = 32'h3F80_0000;
  localparam logic [31:0] ZERO_BITS = 32'h0000_0000;

  // one weight row as it waits in the queue
  typedef struct packed {
    logic [31:0]            weight_bytes;
    logic [31:0]            activation;
    logic [LANES-1:0][31:0] scale;
    logic [LANES-1:0][31:0] offset;
    logic                   first_row;
    logic                   last_row;
  } row_t;

  // one request to the shared fused multiply-add unit: round(a*b + c) or round(a*b)
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic        has_c;
  } fpu_req_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_WAIT,
    S_FINISH
  } back_state_t;

  typedef enum logic [1:0] {
    OP_SCALE,
    OP_OFFSET,
    OP_MAC
  } lane_op_t;

  // exact conversion of an unsigned byte to binary32
  function automatic logic [31:0] byte_to_float(input logic [7:0] q);
    logic [2:0]  p;
    logic [23:0] qs;
    p = 3'd0;
    for (int i = 1; i < 8; i++) begin
      if (q[i]) p = 3'(i);
    end
    qs = 24'(q) << (5'd23 - 5'(p));
    if (q == 8'd0) return ZERO_BITS;
    return {1'b0, 8'(8'd127 + 8'(p)), qs[22:0]};
  endfunction

  // leading zero count of a 64-bit word, 64 when the word is zero
  function automatic logic [6:0] lzc64(input logic [63:0] x);
    logic [6:0] cnt;
    logic       found;
    cnt   = 7'd64;
    found = 1'b0;
    for (int i = 63; i >= 0; i--) begin
      if (!found && x[i]) begin
        cnt   = 7'(63 - i);
        found = 1'b1;
      end
    end
    return cnt;
  endfunction

endpackage

>>> src/dqg_front.sv
// input stage: accepts rows and holds them in a two-entry queue for the back end
module dqg_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [31:0]       weight_bytes,
  input  logic [31:0]       activation,
  input  logic [31:0]       scale_0,
  input  logic [31:0]       scale_1,
  input  logic [31:0]       scale_2,
  input  logic [31:0]       scale_3,
  input  logic [31:0]       offset_0,
  input  logic [31:0]       offset_1,
  input  logic [31:0]       offset_2,
  input  logic [31:0]       offset_3,
  input  logic              first_row,
  input  logic              last_row,
  output logic              q_valid,
  output dqg_pkg::row_t     q_row,
  input  logic              q_pop
);
  import dqg_pkg::*;

  row_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  row_t              in_row;

  assign in_ready = (count != QCNT_W'(QDEPTH));
  assign q_valid  = (count != '0);
  assign push     = in_valid && in_ready;
  assign q_row    = entries[rd_ptr];

  always_comb begin
    in_row.weight_bytes = weight_bytes;
    in_row.activation   = activation;
    in_row.scale        = {scale_3, scale_2, scale_1, scale_0};
    in_row.offset       = {offset_3, offset_2, offset_1, offset_0};
    in_row.first_row    = first_row;
    in_row.last_row     = last_row;
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= in_row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= QPTR_W'(wr_ptr + 1'b1);
      if (q_pop) rd_ptr <= QPTR_W'(rd_ptr + 1'b1);
      if (push && !q_pop) count <= QCNT_W'(count + 1'b1);
      else if (!push && q_pop) count <= QCNT_W'(count - 1'b1);
    end
  end

endmodule

>>> src/dqg_fpu.sv
// shared binary32 fused multiply-add unit, five registered steps per operation
module dqg_fpu (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  dqg_pkg::fpu_req_t req,
  output logic              busy,
  output logic              done,
  output logic [31:0]       result
);
  import dqg_pkg::*;

  // unpack and multiply
  logic                    sa, sb, sc, sp;
  logic [7:0]              ea, eb, ec;
  logic [22:0]             fa, fb, fc;
  logic [23:0]             ma, mb, mc;
  logic signed [EXP_W-1:0] xa, xb, xc;
  logic                    ainf, binf, pinf, any_nan, bad_prod, pzero;
  logic                    sp_u_next, special_u_next, add_u_next;
  logic [31:0]             res_u_next;

  logic                    v_u, sp_u, sc_u, special_u, add_u;
  logic [31:0]             res_u;
  logic [47:0]             psig_u;
  logic signed [EXP_W-1:0] pexp_u, xc_u;
  logic [23:0]             mc_u;

  always_comb begin
    sa = req.a[31]; ea = req.a[30:23]; fa = req.a[22:0];
    sb = req.b[31]; eb = req.b[30:23]; fb = req.b[22:0];
    sc = req.c[31]; ec = req.c[30:23]; fc = req.c[22:0];
    ma = (ea == 8'd0) ? {1'b0, fa} : {1'b1, fa};
    mb = (eb == 8'd0) ? {1'b0, fb} : {1'b1, fb};
    mc = (ec == 8'd0) ? {1'b0, fc} : {1'b1, fc};
    xa = (ea == 8'd0) ? EXP_W'(-149) : $signed(EXP_W'(ea)) - EXP_W'(150);
    xb = (eb == 8'd0) ? EXP_W'(-149) : $signed(EXP_W'(eb)) - EXP_W'(150);
    xc = (ec == 8'd0) ? EXP_W'(-149) : $signed(EXP_W'(ec)) - EXP_W'(150);
    sp       = sa ^ sb;
    ainf     = (ea == 8'hFF);
    binf     = (eb == 8'hFF);
    pinf     = ainf || binf;
    any_nan  = (ainf && fa != '0) || (binf && fb != '0) || (req.has_c && ec == 8'hFF && fc != '0);
    bad_prod = (ainf && !binf && mb == '0) || (binf && !ainf && ma == '0);
    pzero    = (ma == '0) || (mb == '0);
    sp_u_next      = sp;
    special_u_next = 1'b1;
    add_u_next     = 1'b0;
    res_u_next     = QNAN_BITS;
    if (any_nan || bad_prod) begin
      res_u_next = QNAN_BITS;
    end else if (req.has_c && ec == 8'hFF) begin
      res_u_next = (pinf && sp != sc) ? QNAN_BITS : {sc, 8'hFF, 23'd0};
    end else if (pinf) begin
      res_u_next = {sp, 8'hFF, 23'd0};
    end else if (!req.has_c || mc == '0) begin
      if (pzero) res_u_next = req.has_c ? {sp & sc, 31'd0} : {sp, 31'd0};
      else special_u_next = 1'b0;
    end else if (pzero) begin
      res_u_next = req.c;
    end else begin
      special_u_next = 1'b0;
      add_u_next     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sp_u      <= sp_u_next;
      sc_u      <= sc;
      special_u <= special_u_next;
      add_u     <= add_u_next;
      res_u     <= res_u_next;
      psig_u    <= ma * mb;
      pexp_u    <= xa + xb;
      mc_u      <= mc;
      xc_u      <= xc;
    end
  end

  // normalize product and addend to bit 62
  logic [63:0]             p64, c64;
  logic [6:0]              lzp, lzc_c;
  logic                    v_n, sp_n, sc_n, special_n, add_n;
  logic [31:0]             res_n;
  logic [63:0]             psig_n, mc_n;
  logic signed [EXP_W-1:0] pexp_n, xc_n;

  always_comb begin
    p64   = 64'(psig_u);
    c64   = 64'(mc_u);
    lzp   = lzc64(p64);
    lzc_c = lzc64(c64);
  end

  always_ff @(posedge clk) begin
    sp_n      <= sp_u;
    sc_n      <= sc_u;
    special_n <= special_u;
    add_n     <= add_u;
    res_n     <= res_u;
    psig_n    <= p64 << (lzp - 7'd1);
    pexp_n    <= pexp_u - $signed(EXP_W'(lzp - 7'd1));
    mc_n      <= c64 << (lzc_c - 7'd1);
    xc_n      <= xc_u - $signed(EXP_W'(lzc_c - 7'd1));
  end

  // align and add
  logic                    p_big, sx;
  logic signed [EXP_W-1:0] ex, ey, dexp;
  logic [63:0]             xs, ys, ysj, jmask;
  logic [5:0]              dsh;
  logic                    sign_a_next, special_a_next;
  logic [31:0]             res_a_next;
  logic [63:0]             sig_a_next;
  logic signed [EXP_W-1:0] exp_a_next;

  logic                    v_a, sign_a, special_a;
  logic [31:0]             res_a;
  logic [63:0]             sig_a;
  logic signed [EXP_W-1:0] exp_a;

  always_comb begin
    p_big = (pexp_n > xc_n) || (pexp_n == xc_n && psig_n >= mc_n);
    sx = p_big ? sp_n : sc_n;
    ex = p_big ? pexp_n : xc_n;
    xs = p_big ? psig_n : mc_n;
    ey = p_big ? xc_n : pexp_n;
    ys = p_big ? mc_n : psig_n;
    dexp  = ex - ey;
    dsh   = dexp[5:0];
    jmask = (64'd1 << dsh) - 64'd1;
    if (dexp >= EXP_W'(63)) ysj = 64'(|ys);
    else ysj = (ys >> dsh) | 64'(|(ys & jmask));
    sign_a_next    = sp_n;
    exp_a_next     = pexp_n;
    sig_a_next     = psig_n;
    special_a_next = special_n;
    res_a_next     = res_n;
    if (add_n) begin
      sign_a_next = sx;
      exp_a_next  = ex;
      if (sp_n == sc_n) begin
        sig_a_next = xs + ysj;
      end else if (xs == ysj) begin
        special_a_next = 1'b1;
        res_a_next     = ZERO_BITS;
      end else begin
        sig_a_next = xs - ysj;
      end
    end
  end

  always_ff @(posedge clk) begin
    sign_a    <= sign_a_next;
    exp_a     <= exp_a_next;
    sig_a     <= sig_a_next;
    special_a <= special_a_next;
    res_a     <= res_a_next;
  end

  // normalize to bit 63 and find the rounding position
  logic [6:0]              lzs;
  logic signed [EXP_W-1:0] e_full, s_full;
  logic [6:0]              s_r1_next;

  logic                    v_r1, sign_r1, special_r1;
  logic [31:0]             res_r1;
  logic [63:0]             sig_r1;
  logic signed [EXP_W-1:0] e_r1;
  logic [6:0]              s_r1;

  always_comb begin
    lzs    = lzc64(sig_a);
    e_full = exp_a - $signed(EXP_W'(lzs)) + EXP_W'(190);
    s_full = EXP_W'(41) - e_full;
    if (e_full >= EXP_W'(1)) s_r1_next = 7'd40;
    else if (s_full > EXP_W'(65)) s_r1_next = 7'd65;
    else s_r1_next = s_full[6:0];
  end

  always_ff @(posedge clk) begin
    sign_r1    <= sign_a;
    special_r1 <= special_a;
    res_r1     <= res_a;
    sig_r1     <= sig_a << lzs;
    e_r1       <= e_full;
    s_r1       <= s_r1_next;
  end

  // round to nearest even and pack
  logic [127:0]            ext;
  logic                    guard, sticky;
  logic [24:0]             m_r;
  logic [EXP_W-1:0]        em1;
  logic [39:0]             bits;
  logic [31:0]             res_r2_next;

  always_comb begin
    ext    = {sig_r1, 64'd0} >> s_r1;
    guard  = ext[63];
    sticky = |ext[62:0];
    m_r    = 25'(ext[87:64]) + 25'(guard && (sticky || ext[64]));
    em1    = EXP_W'(e_r1 - EXP_W'(1));
    bits   = (40'(em1) << 23) + 40'(m_r);
    if (special_r1) begin
      res_r2_next = res_r1;
    end else if (e_r1 >= EXP_W'(1)) begin
      if (bits >= 40'h7F80_0000) res_r2_next = {sign_r1, 8'hFF, 23'd0};
      else res_r2_next = {sign_r1, bits[30:0]};
    end else begin
      res_r2_next = {sign_r1, 6'd0, m_r};
    end
  end

  always_ff @(posedge clk) begin
    result <= res_r2_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_u  <= 1'b0;
      v_n  <= 1'b0;
      v_a  <= 1'b0;
      v_r1 <= 1'b0;
      done <= 1'b0;
    end else begin
      v_u  <= start;
      v_n  <= v_u;
      v_a  <= v_n;
      v_r1 <= v_a;
      done <= v_r1;
    end
  end

  assign busy = v_u || v_n || v_a || v_r1;

endmodule

>>> src/dqg_back.sv
// back end: walks the four lanes through scale, offset and accumulate on the shared unit
module dqg_back (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  q_valid,
  input  dqg_pkg::row_t                         q_row,
  output logic                                  q_pop,
  output logic                                  fpu_start,
  output dqg_pkg::fpu_req_t                     fpu_req,
  input  logic                                  fpu_done,
  input  logic [31:0]                           fpu_result,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [dqg_pkg::LANES-1:0][31:0]       sums
);
  import dqg_pkg::*;

  back_state_t            state, state_next;
  lane_op_t               op;
  logic [LANE_W-1:0]      lane;
  logic [31:0]            tmp;
  logic [LANES-1:0][31:0] acc;
  logic [LANES-1:0][7:0]  wb;
  logic                   out_load;
  logic                   row_start;
  logic                   lane_last;

  assign wb        = q_row.weight_bytes;
  assign lane_last = (lane == LANE_W'(LANES - 1));

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    fpu_start  = 1'b0;
    out_load   = 1'b0;
    row_start  = 1'b0;
    case (state)
      S_IDLE: begin
        if (q_valid) begin
          row_start  = 1'b1;
          state_next = S_ISSUE;
        end
      end
      S_ISSUE: begin
        fpu_start  = 1'b1;
        state_next = S_WAIT;
      end
      S_WAIT: begin
        if (fpu_done) state_next = (op == OP_MAC && lane_last) ? S_FINISH : S_ISSUE;
      end
      S_FINISH: begin
        if (!q_row.last_row) begin
          q_pop      = 1'b1;
          state_next = S_IDLE;
        end else if (!out_valid || out_ready) begin
          q_pop      = 1'b1;
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    case (op)
      OP_SCALE: begin
        fpu_req.a     = byte_to_float(wb[lane]);
        fpu_req.b     = q_row.scale[lane];
        fpu_req.c     = ZERO_BITS;
        fpu_req.has_c = 1'b0;
      end
      OP_OFFSET: begin
        fpu_req.a     = tmp;
        fpu_req.b     = ONE_BITS;
        fpu_req.c     = q_row.offset[lane];
        fpu_req.has_c = 1'b1;
      end
      OP_MAC: begin
        fpu_req.a     = tmp;
        fpu_req.b     = q_row.activation;
        fpu_req.c     = acc[lane];
        fpu_req.has_c = 1'b1;
      end
      default: begin
        fpu_req.a     = tmp;
        fpu_req.b     = ONE_BITS;
        fpu_req.c     = ZERO_BITS;
        fpu_req.has_c = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op        <= OP_SCALE;
      lane      <= '0;
      acc       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (row_start) begin
        op   <= OP_SCALE;
        lane <= '0;
        if (q_row.first_row) acc <= '0;
      end else if (state == S_WAIT && fpu_done) begin
        case (op)
          OP_SCALE:  op <= OP_OFFSET;
          OP_OFFSET: op <= OP_MAC;
          OP_MAC: begin
            acc[lane] <= fpu_result;
            op        <= OP_SCALE;
            lane      <= LANE_W'(lane + 1'b1);
          end
          default: op <= OP_SCALE;
        endcase
      end
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_WAIT && fpu_done) tmp <= fpu_result;
    if (out_load) sums <= acc;
  end

endmodule

>>> src/dequant_uint8_gemv_mac4_core.sv
// top level of the uint8 dequantizing four-lane gemv core
// each input word is one weight row: four packed uint8 weights, one binary32
// activation and the four per-column scales and offsets. every weight is
// dequantized as round(round(q*scale) + offset) and then fused into its lane
// as acc = round(acc + w*activation), all binary32 round-to-nearest-even with
// subnormals kept; any nan gives the quiet nan 0x7fc00000. first_row clears
// the four sums to +0.0 before the row, last_row emits one output word with
// the four sums after it. a two-entry queue takes rows while the back end
// works and while a finished output word waits. the back end runs twelve
// operations per row (three per lane) through one shared five-step fused
// multiply-add unit, one operation at a time; that unit and the dependence
// of each sum on the previous one set the row rate.
module dequant_uint8_gemv_mac4_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] weight_bytes,
  input  logic [31:0] activation,
  input  logic [31:0] scale_0,
  input  logic [31:0] scale_1,
  input  logic [31:0] scale_2,
  input  logic [31:0] scale_3,
  input  logic [31:0] offset_0,
  input  logic [31:0] offset_1,
  input  logic [31:0] offset_2,
  input  logic [31:0] offset_3,
  input  logic        first_row,
  input  logic        last_row,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] sum_0,
  output logic [31:0] sum_1,
  output logic [31:0] sum_2,
  output logic [31:0] sum_3
);
  import dqg_pkg::*;

  // queue to back end
  logic                   q_valid;
  logic                   q_pop;
  row_t                   q_row;

  // back end to shared unit
  logic                   fpu_start;
  logic                   fpu_busy;
  logic                   fpu_done;
  fpu_req_t               fpu_req;
  logic [31:0]            fpu_result;

  logic [LANES-1:0][31:0] sums;

  // row intake and queue
  dqg_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .weight_bytes (weight_bytes),
    .activation   (activation),
    .scale_0      (scale_0),
    .scale_1      (scale_1),
    .scale_2      (scale_2),
    .scale_3      (scale_3),
    .offset_0     (offset_0),
    .offset_1     (offset_1),
    .offset_2     (offset_2),
    .offset_3     (offset_3),
    .first_row    (first_row),
    .last_row     (last_row),
    .q_valid      (q_valid),
    .q_row        (q_row),
    .q_pop        (q_pop)
  );

  // lane sequencer, accumulators and output register
  dqg_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_row      (q_row),
    .q_pop      (q_pop),
    .fpu_start  (fpu_start),
    .fpu_req    (fpu_req),
    .fpu_done   (fpu_done),
    .fpu_result (fpu_result),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sums       (sums)
  );

  // shared fused multiply-add
  dqg_fpu u_fpu (
    .clk    (clk),
    .rst    (rst),
    .start  (fpu_start),
    .req    (fpu_req),
    .busy   (fpu_busy),
    .done   (fpu_done),
    .result (fpu_result)
  );

  assign sum_0 = sums[0];
  assign sum_1 = sums[1];
  assign sum_2 = sums[2];
  assign sum_3 = sums[3];

`ifndef SYNTHESIS
  // a row leaves the queue only when one is there
  a_pop_has_row: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid) else $error("queue popped while empty");

  // the shared unit never gets a second operation in flight
  a_fpu_single: assert property (@(posedge clk) disable iff (rst)
    fpu_start |-> !fpu_busy && !fpu_done) else $error("fpu started while busy");

  // a new output word comes only with the row that produced it
  a_out_from_pop: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(q_pop)) else $error("output word without a finished row");

  // a full queue must hold something for the back end
  a_full_not_empty: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> q_valid) else $error("queue stalls input while empty");
`endif

endmodule

>>> tb/sv/dequant_uint8_gemv_mac4_core_chk.sv
// checker for the uint8 dequantizing gemv core: binary32 predictor and sum compare
module dequant_uint8_gemv_mac4_core_chk (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [31:0] weight_bytes,
  input  logic [31:0] activation,
  input  logic [31:0] scale_0,
  input  logic [31:0] scale_1,
  input  logic [31:0] scale_2,
  input  logic [31:0] scale_3,
  input  logic [31:0] offset_0,
  input  logic [31:0] offset_1,
  input  logic [31:0] offset_2,
  input  logic [31:0] offset_3,
  input  logic        first_row,
  input  logic        last_row,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] sum_0,
  input  logic [31:0] sum_1,
  input  logic [31:0] sum_2,
  input  logic [31:0] sum_3,
  output int          fail_count,
  output int          sums_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import dqg_pkg::*;

  logic [LANES-1:0][31:0] lane_sum;
  logic [LANES-1:0][31:0] sums_due[$];

  function automatic logic [63:0] sticky_shift(logic [63:0] sig, int d);
    if (d <= 0) return sig;
    if (d >= 63) return (sig != 0) ? 64'd1 : 64'd0;
    return (sig >> d) | 64'(((sig & ((64'd1 << d) - 64'd1)) != 0));
  endfunction

  // sig * 2^ex rounded to nearest even, subnormals kept, overflow to infinity
  function automatic logic [31:0] f32_round(logic sgn, int ex, logic [63:0] sig);
    int          e, s;
    logic [63:0] m, rem, half, bits;
    while (!sig[63]) begin
      sig = sig << 1;
      ex--;
    end
    e = ex + 190;
    s = (e >= 1) ? 40 : 41 - e;
    if (s >= 64) begin
      m = (s == 64 && sig > (64'd1 << 63)) ? 64'd1 : 64'd0;
    end else begin
      m    = sig >> s;
      rem  = sig & ((64'd1 << s) - 64'd1);
      half = 64'd1 << (s - 1);
      if (rem > half || (rem == half && m[0])) m++;
    end
    if (e >= 1) begin
      bits = (64'(e - 1) << 23) + m;
      if (bits >= 64'h7F80_0000) bits = 64'h7F80_0000;
    end else begin
      bits = m;
    end
    return {sgn, bits[30:0]};
  endfunction

  function automatic void f32_split(logic [31:0] x, output logic [63:0] sig, output int ex);
    if (x[30:23] == 8'd0) begin
      sig = 64'(x[22:0]);
      ex  = -149;
    end else begin
      sig = 64'({1'b1, x[22:0]});
      ex  = int'(x[30:23]) - 150;
    end
  endfunction

  function automatic logic [63:0] lift62(logic [63:0] sig, inout int ex);
    while (!sig[62]) begin
      sig = sig << 1;
      ex--;
    end
    return sig;
  endfunction

  // round(a*b + c), or round(a*b) when add_c is low
  function automatic logic [31:0] f32_fma(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                          logic add_c);
    logic [63:0] ma, mb, mc, psig, xs, ys;
    int          xa, xb, xc, pexp, ex, ey;
    logic        sp, sx, ainf, binf, pinf, anan, bnan, cnan;
    f32_split(a, ma, xa);
    f32_split(b, mb, xb);
    f32_split(c, mc, xc);
    sp   = a[31] ^ b[31];
    ainf = (a[30:23] == 8'hFF);
    binf = (b[30:23] == 8'hFF);
    anan = ainf && a[22:0] != 0;
    bnan = binf && b[22:0] != 0;
    cnan = add_c && c[30:23] == 8'hFF && c[22:0] != 0;
    if (anan || bnan || cnan) return QNAN_BITS;
    if ((ainf && !binf && mb == 0) || (binf && !ainf && ma == 0)) return QNAN_BITS;
    pinf = ainf || binf;
    if (add_c && c[30:23] == 8'hFF) begin
      if (pinf && sp != c[31]) return QNAN_BITS;
      return {c[31], 31'h7F80_0000};
    end
    if (pinf) return {sp, 31'h7F80_0000};
    psig = ma * mb;
    pexp = xa + xb;
    if (!add_c || mc == 0) begin
      if (psig == 0) return add_c ? {sp & c[31], 31'd0} : {sp, 31'd0};
      return f32_round(sp, pexp, psig);
    end
    if (psig == 0) return c;
    psig = lift62(psig, pexp);
    mc   = lift62(mc, xc);
    if (pexp > xc || (pexp == xc && psig >= mc)) begin
      sx = sp;    ex = pexp; xs = psig; ey = xc;   ys = mc;
    end else begin
      sx = c[31]; ex = xc;   xs = mc;   ey = pexp; ys = psig;
    end
    ys = sticky_shift(ys, ex - ey);
    if (sp == c[31]) return f32_round(sx, ex, xs + ys);
    if (xs == ys) return ZERO_BITS;
    return f32_round(sx, ex, xs - ys);
  endfunction

  function automatic logic [31:0] u8_to_f32(logic [7:0] q);
    int msb;
    msb = 0;
    if (q == 0) return ZERO_BITS;
    for (int i = 0; i < 8; i++) if (q[i]) msb = i;
    return {1'b0, 8'(127 + msb), 23'(32'(q) << (23 - msb))};
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  assign sums_pending = sums_due.size();

  always @(posedge clk) begin
    logic [LANES-1:0][31:0] sc, of, got, want;
    logic [31:0]            w;
    if (rst) begin
      lane_sum   <= '0;
      fail_count <= 0;
    end else begin
      if (in_valid && in_ready) begin
        sc = {scale_3, scale_2, scale_1, scale_0};
        of = {offset_3, offset_2, offset_1, offset_0};
        want = first_row ? '0 : lane_sum;
        for (int j = 0; j < LANES; j++) begin
          w = f32_fma(u8_to_f32(weight_bytes[8*j +: 8]), sc[j], ZERO_BITS, 1'b0);
          w = f32_fma(w, ONE_BITS, of[j], 1'b1);
          want[j] = f32_fma(w, activation, want[j], 1'b1);
        end
        lane_sum <= want;
        if (last_row) sums_due.push_back(want);
      end
      if (out_valid && out_ready) begin
        got = {sum_3, sum_2, sum_1, sum_0};
        if (sums_due.size() == 0) begin
          $display("unexpected output word %h at %0t", got, $realtime);
          fail_count++;
        end else begin
          want = sums_due.pop_front();
          for (int j = 0; j < LANES; j++)
            if (got[j] !== want[j]) report_mismatch($sformatf("sum_%0d", j), got[j], want[j]);
        end
      end
    end
  end

endmodule

>>> tb/sv/dequant_uint8_gemv_mac4_core_tb.sv
// testbench top for the uint8 dequantizing gemv core: stimulus, stalls and verdict
module dequant_uint8_gemv_mac4_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dqg_pkg::*;

  // one weight row as driven onto the input channel
  typedef struct {
    logic [31:0]            wb;
    logic [31:0]            act;
    logic [LANES-1:0][31:0] sc;
    logic [LANES-1:0][31:0] of;
    logic                   first;
    logic                   last;
  } row_word_t;

  logic        clk, rst;
  logic        in_valid, in_ready, out_valid, out_ready;
  logic [31:0] weight_bytes, activation;
  logic [31:0] scale_0, scale_1, scale_2, scale_3;
  logic [31:0] offset_0, offset_1, offset_2, offset_3;
  logic        first_row, last_row;
  logic [31:0] sum_0, sum_1, sum_2, sum_3;
  int          fail_count, sums_pending;
  int          burst_left;
  bit          stim_done;

  // binary32 corner values: zeros, infinities, nans, subnormals, extremes
  localparam logic [31:0] EDGE_F[13] = '{
    32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000,
    32'h7F80_0001, 32'hFFFF_FFFF, 32'h0000_0001, 32'h807F_FFFF, 32'h7F7F_FFFF,
    32'hFF7F_FFFF, 32'h3F80_0000, 32'h0080_0000};

  dequant_uint8_gemv_mac4_core u_dut (.*);

  dequant_uint8_gemv_mac4_core_chk u_chk (.*);

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // mostly well-scaled values so sums stay finite, with corners and raw noise mixed in
  function automatic logic [31:0] pick_float();
    int sel;
    sel = $urandom_range(0, 15);
    if (sel == 0) return EDGE_F[$urandom_range(0, 12)];
    if (sel == 1) return $urandom;
    return {1'($urandom), 8'($urandom_range(112, 136)), 23'($urandom)};
  endfunction

  function automatic row_word_t random_row(logic first, logic last);
    row_word_t r;
    r.wb    = $urandom;
    r.act   = pick_float();
    for (int j = 0; j < LANES; j++) begin
      r.sc[j] = pick_float();
      r.of[j] = pick_float();
    end
    r.first = first;
    r.last  = last;
    return r;
  endfunction

  // present one word at the falling edge and hold it until the core takes it
  task automatic push_row(row_word_t r);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    in_valid     <= 1'b1;
    weight_bytes <= r.wb;
    activation   <= r.act;
    {scale_3, scale_2, scale_1, scale_0}     <= r.sc;
    {offset_3, offset_2, offset_1, offset_0} <= r.of;
    first_row    <= r.first;
    last_row     <= r.last;
    do @(posedge clk); while (!(in_valid && in_ready));
    @(negedge clk);
    burst_left--;
  endtask

  // uniform row: same scale, offset for every lane
  function automatic row_word_t flat_row(logic [31:0] wb, logic [31:0] act, logic [31:0] sc,
                                         logic [31:0] of, logic first, logic last);
    row_word_t r;
    r.wb = wb;
    r.act = act;
    r.sc = {LANES{sc}};
    r.of = {LANES{of}};
    r.first = first;
    r.last = last;
    return r;
  endfunction

  // receiver stall pattern: phases of always ready, light and heavy stalling
  always @(negedge clk) begin
    int mode_left, mode;
    if (rst) begin
      out_ready <= 1'b0;
      mode_left = 0;
    end else begin
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 400);
      end
      mode_left--;
      case (mode)
        0: begin
          out_ready <= 1'b1;
        end
        1: begin
          out_ready <= ($urandom_range(0, 3) != 0);
        end
        default: begin
          out_ready <= ($urandom_range(0, 7) == 0);
        end
      endcase
    end
  end

  initial begin
    row_word_t r;
    int        len;
    in_valid = 1'b0;
    weight_bytes = '0;
    activation = '0;
    {scale_3, scale_2, scale_1, scale_0} = '0;
    {offset_3, offset_2, offset_1, offset_0} = '0;
    first_row = 1'b0;
    last_row = 1'b0;
    burst_left = 0;
    stim_done = 1'b0;
    rst = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // byte extremes with exact unit scale
    push_row(flat_row(32'hFF7F_0100, ONE_BITS, ONE_BITS, ZERO_BITS, 1'b1, 1'b1));
    // overflow to infinity
    push_row(flat_row(32'hFFFF_FFFF, 32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h7F7F_FFFF, 1'b1, 1'b1));
    // nan scale, zero times infinity, infinity minus infinity, signaling nan offset
    r = flat_row(32'h0101_0001, ONE_BITS, ONE_BITS, ZERO_BITS, 1'b1, 1'b1);
    r.sc = {ONE_BITS, 32'h7F80_0000, 32'h7F80_0000, 32'h7FC0_0001};
    r.of = {32'h7F80_0001, 32'hFF80_0000, ZERO_BITS, ZERO_BITS};
    push_row(r);
    // nan and infinite activations
    push_row(flat_row(32'h1234_5678, 32'hFFC0_0123, ONE_BITS, ONE_BITS, 1'b1, 1'b1));
    push_row(flat_row(32'h0000_0000, 32'hFF80_0000, ONE_BITS, ZERO_BITS, 1'b1, 1'b1));
    // zero signs: negative zero weight, cancellation to +0
    push_row(flat_row(32'h0000_0000, 32'hBF80_0000, 32'hBF80_0000, 32'h8000_0000, 1'b1, 1'b1));
    push_row(flat_row(32'h0202_0202, ONE_BITS, ONE_BITS, 32'hC000_0000, 1'b1, 1'b1));
    push_row(flat_row(32'h0303_0303, 32'h8000_0000, ONE_BITS, ZERO_BITS, 1'b0, 1'b1));
    // subnormal scales and offsets, all the way down to the smallest
    push_row(flat_row(32'h80FF_0201, 32'h3F00_0000, 32'h0000_0001, 32'h807F_FFFF, 1'b1, 1'b0));
    push_row(flat_row(32'h0A0B_0C0D, 32'h0080_0000, 32'h0080_0000, 32'h0000_0003, 1'b0, 1'b1));
    // no first row: keep accumulating across an emit
    push_row(flat_row(32'h0102_0304, 32'h4000_0000, 32'h3E80_0000, 32'h3F80_0000, 1'b0, 1'b0));
    push_row(flat_row(32'h4080_C0FF, 32'hC040_0000, 32'h3C00_0000, 32'hBF00_0000, 1'b0, 1'b1));
    push_row(flat_row(32'h7F7F_7F7F, 32'h3F80_0000, 32'h3F80_0000, 32'h0000_0000, 1'b0, 1'b1));
    // only a first row, then a lone emit
    push_row(flat_row(32'hAA55_AA55, 32'h7F80_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0));
    push_row(flat_row(32'h55AA_55AA, 32'h3F80_0000, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b1));

    // random part: mostly whole dot products, some loose rows
    for (int n = 0; n < 700; ) begin
      if ($urandom_range(0, 5) == 0) begin
        push_row(random_row(1'($urandom), 1'($urandom)));
        n++;
      end else begin
        len = $urandom_range(1, 8);
        for (int k = 0; k < len; k++) push_row(random_row(k == 0, k == len - 1));
        n += len;
      end
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // wait for the last sums, then give the core time to show any stray word
  initial begin
    wait (stim_done);
    while (sums_pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS dequant_uint8_gemv_mac4_core");
    end else begin
      $display("FAIL dequant_uint8_gemv_mac4_core");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("FAIL dequant_uint8_gemv_mac4_core");
    $finish;
  end

endmodule
